/* rtl/core/mcsp_pkg.sv */
// Shared types, constants and the opcode range decoder of the song command stream parser.
// Used by every module in rtl/core; depends on nothing.
package mcsp_pkg;

	localparam logic [7:0] HDR_LONG      = 8'hfe;
	localparam logic [7:0] HDR_SHORT     = 8'h0c;
	localparam logic [2:0] HDR_LONG_SKIP = 3'd6;
	localparam logic [2:0] HDR_SHORT_SKIP = 3'd1;
	localparam logic [7:0] FUNC_MAX      = 8'd11;
	localparam logic [7:0] FUNC_PAIR_LO  = 8'd8;
	localparam logic [7:0] FUNC_PAIR_HI  = 8'd9;

	localparam logic [4:0] CMD_LOOP_START = 5'd10;
	localparam logic [4:0] CMD_LOOP_END   = 5'd11;
	localparam logic [4:0] CMD_LOOP_EXT   = 5'd18;
	localparam logic [4:0] CMD_REG_WRITE  = 5'd20;
	localparam logic [4:0] CMD_FUNCTION   = 5'd22;

	// Commands complete in one word without a parameter, and with an inline parameter.
	localparam logic [31:0] CMD_BARE_MASK   = 32'h0000_00dd;
	localparam logic [31:0] CMD_INLINE_MASK = 32'h0001_b722;

	localparam logic [2:0] KIND_CH_START = 3'd0;
	localparam logic [2:0] KIND_COMMAND  = 3'd1;
	localparam logic [2:0] KIND_END      = 3'd2;
	localparam logic [2:0] KIND_NOT_SONG = 3'd3;
	localparam logic [2:0] KIND_CORRUPT  = 3'd4;

	localparam logic [3:0] PSG_RESET = 4'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
		logic [4:0] command;
		logic [7:0] param;
	} item_t;

	typedef struct packed {
		logic [2:0]        result_kind;
		logic [7:0]        channel;
		logic              chip;
		logic [15:0]       channel_address;
		logic [4:0]        command;
		logic [7:0]        param;
		logic [7:0]        second_param;
		logic              has_second;
		logic signed [7:0] loop_depth;
		logic              bad_loop_end;
		logic              bad_function;
	} result_t;

	typedef enum logic [7:0] {
		PH_HEADER  = 8'b0000_0001,
		PH_SKIP    = 8'b0000_0010,
		PH_ADDR_LO = 8'b0000_0100,
		PH_ADDR_HI = 8'b0000_1000,
		PH_OPCODE  = 8'b0001_0000,
		PH_EXT1    = 8'b0010_0000,
		PH_EXT2    = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	// Priority compare over the opcode ranges; returns {command, param}.
	function automatic logic [12:0] decode_op(input logic [7:0] op);
		logic [4:0] cmd;
		logic [7:0] par;
		cmd = 5'd0;
		par = 8'd0;
		if (op == 8'd0) begin
			cmd = 5'd0;
		end else if (op < 8'd37) begin
			cmd = 5'd1;
			par = op - 8'd1;
		end else if (op < 8'd38) begin
			cmd = 5'd2;
		end else if (op < 8'd40) begin
			par = op - 8'd38;
			cmd = 5'd3 + par[4:0];
		end else if (op < 8'd48) begin
			cmd = 5'd5;
			par = op - 8'd40;
		end else if (op < 8'd50) begin
			par = op - 8'd48;
			cmd = 5'd6 + par[4:0];
		end else if (op < 8'd66) begin
			cmd = 5'd8;
			par = op - 8'd50;
		end else if (op < 8'd98) begin
			cmd = 5'd9;
			par = op - 8'd66;
		end else if (op < 8'd114) begin
			cmd = 5'd10;
			par = op - 8'd98;
		end else if (op < 8'd115) begin
			cmd = 5'd11;
		end else if (op < 8'd131) begin
			cmd = 5'd12;
			par = op - 8'd115;
		end else if (op < 8'd147) begin
			cmd = 5'd13;
			par = op - 8'd131;
		end else if (op < 8'd151) begin
			cmd = 5'd14;
			par = op - 8'd147;
		end else if (op < 8'd242) begin
			cmd = 5'd15;
			par = op - 8'd151;
		end else if (op < 8'd250) begin
			cmd = 5'd16;
			par = op - 8'd242;
		end else begin
			par = op - 8'd250;
			cmd = 5'd17 + par[4:0];
		end
		return {cmd, par};
	endfunction

endpackage

/* rtl/core/mcsp_if.sv */
// Handshake channels of the song command stream parser: song words in, results out, config.
// Depends on nothing.
interface mcsp_song_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_file;
	modport source (output valid, output data_byte, output first_of_file, input ready);
	modport sink (input valid, input data_byte, input first_of_file, output ready);
endinterface

interface mcsp_result_if;
	logic              valid;
	logic              ready;
	logic [2:0]        result_kind;
	logic [7:0]        channel;
	logic              chip;
	logic [15:0]       channel_address;
	logic [4:0]        command;
	logic [7:0]        param;
	logic [7:0]        second_param;
	logic              has_second;
	logic signed [7:0] loop_depth;
	logic              bad_loop_end;
	logic              bad_function;
	modport source (output valid, output result_kind, output channel, output chip,
		output channel_address, output command, output param, output second_param,
		output has_second, output loop_depth, output bad_loop_end, output bad_function,
		input ready);
	modport sink (input valid, input result_kind, input channel, input chip,
		input channel_address, input command, input param, input second_param,
		input has_second, input loop_depth, input bad_loop_end, input bad_function,
		output ready);
endinterface

interface mcsp_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] psg_channel_count;
	modport source (output valid, output psg_channel_count, input ready);
	modport sink (input valid, input psg_channel_count, output ready);
endinterface

/* rtl/core/music_command_stream_parser_top.sv */
// Top level of the song command stream parser: front end, word queue, back end, config register.
// Depends on mcsp_pkg, the channel interfaces, mcsp_front, mcsp_queue and mcsp_back.
//
// The parser takes one song word per cycle and gives at most one result word per word taken,
// as long as the results are taken. A word passes the front decode register, the queue and
// the back end's state machine, which registers the result word; the back end's
// one-word-per-cycle state update sets the sustained rate of one word per cycle while results
// are taken. The queue of QUEUE_DEPTH words lets the input keep flowing for a while when
// results are not taken. Write psg_channel_count only while the parser is idle.
module music_command_stream_parser_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	mcsp_song_if.sink     song,
	mcsp_cfg_if.sink      cfg,
	mcsp_result_if.source result
);

	mcsp_pkg::item_t front_item;
	logic            front_valid;
	logic            front_ready;
	mcsp_pkg::item_t back_item;
	logic            back_valid;
	logic            back_ready;
	logic [3:0]      psg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psg_q <= mcsp_pkg::PSG_RESET;
		end else if (cfg.valid) begin
			psg_q <= cfg.psg_channel_count;
		end
	end

	mcsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.song       (song),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	mcsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_item   (back_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	mcsp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.item              (back_item),
		.item_valid        (back_valid),
		.item_ready        (back_ready),
		.psg_channel_count (psg_q),
		.result            (result)
	);

endmodule

/* rtl/core/mcsp_front.sv */
// Front end: accepts song words, range-decodes the opcode and registers the classified word.
// Depends on mcsp_pkg and mcsp_song_if.
module mcsp_front (
	input  logic            clk,
	input  logic            arst_n,
	mcsp_song_if.sink       song,
	output mcsp_pkg::item_t item,
	output logic            item_valid,
	input  logic            item_ready
);

	logic            valid_s1;
	mcsp_pkg::item_t item_s1;
	logic [12:0]     dec;

	assign dec        = mcsp_pkg::decode_op(song.data_byte);
	assign song.ready = !valid_s1 || item_ready;
	assign item       = item_s1;
	assign item_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (song.ready) begin
			valid_s1 <= song.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (song.valid && song.ready) begin
			item_s1.data_byte     <= song.data_byte;
			item_s1.first_of_file <= song.first_of_file;
			item_s1.command       <= dec[12:8];
			item_s1.param         <= dec[7:0];
		end
	end

endmodule

/* rtl/core/mcsp_queue.sv */
// Short queue of classified words between the front end and the back end.
// Depends on mcsp_pkg.
module mcsp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mcsp_pkg::item_t push_item,
	input  logic            push_valid,
	output logic            push_ready,
	output mcsp_pkg::item_t pop_item,
	output logic            pop_valid,
	input  logic            pop_ready
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	mcsp_pkg::item_t entry_q [DEPTH];
	logic [IW-1:0]   wr_q;
	logic [IW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/mcsp_back.sv */
// Back end: the song parsing state machine, loop nesting and the registered result word.
// Depends on mcsp_pkg and mcsp_result_if.
module mcsp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mcsp_pkg::item_t item,
	input  logic            item_valid,
	output logic            item_ready,
	input  logic [3:0]      psg_channel_count,
	mcsp_result_if.source   result
);

	mcsp_pkg::phase_t  phase_q, ph, phase_d;
	logic [15:0]       pos_q, pos, pos_d, pos_n;
	logic [15:0]       chend_q, chend, chend_d;
	logic [7:0]        chidx_q, chidx, chidx_d, chidx_inc;
	logic signed [7:0] nest_q, nest, nest_d, nest_up, nest_dn;
	logic [2:0]        skip_q, skip, skip_d, skip_m;
	logic [4:0]        pcmd_q, pcmd, pcmd_d;
	logic [7:0]        pbyte_q, pbyte, pbyte_d;
	logic [7:0]        alow_q, alow, alow_d;
	logic [15:0]       addr;
	logic              end_hit;
	logic              emit;
	logic              take;
	logic [7:0]        b;
	mcsp_pkg::result_t res, res_q;
	logic              out_valid_q;

	assign take       = item_valid && (!out_valid_q || result.ready);
	assign item_ready = !out_valid_q || result.ready;
	assign b          = item.data_byte;

	always_comb begin
		ph    = item.first_of_file ? mcsp_pkg::PH_HEADER : phase_q;
		pos   = item.first_of_file ? '0 : pos_q;
		chend = item.first_of_file ? '0 : chend_q;
		chidx = item.first_of_file ? '0 : chidx_q;
		nest  = item.first_of_file ? '0 : nest_q;
		skip  = item.first_of_file ? '0 : skip_q;
		pcmd  = item.first_of_file ? '0 : pcmd_q;
		pbyte = item.first_of_file ? '0 : pbyte_q;
		alow  = item.first_of_file ? '0 : alow_q;

		pos_n     = pos + 16'd1;
		addr      = {b, alow};
		end_hit   = pos_n >= chend;
		chidx_inc = (chidx == 8'hff) ? chidx : chidx + 8'd1;
		nest_up   = (nest == 8'sd127) ? nest : nest + 8'sd1;
		nest_dn   = (nest == -8'sd128) ? nest : nest - 8'sd1;
		skip_m    = (skip != '0) ? skip - 3'd1 : skip;

		phase_d = ph;
		pos_d   = pos_n;
		chend_d = chend;
		chidx_d = chidx;
		nest_d  = nest;
		skip_d  = skip;
		pcmd_d  = pcmd;
		pbyte_d = pbyte;
		alow_d  = alow;
		emit    = 1'b0;
		res     = '0;
		res.result_kind = mcsp_pkg::KIND_COMMAND;

		unique case (ph)
			mcsp_pkg::PH_HEADER: begin
				pos_d = 16'd1;
				if (b == mcsp_pkg::HDR_LONG) begin
					skip_d  = mcsp_pkg::HDR_LONG_SKIP;
					phase_d = mcsp_pkg::PH_SKIP;
				end else if (b == mcsp_pkg::HDR_SHORT) begin
					skip_d  = mcsp_pkg::HDR_SHORT_SKIP;
					phase_d = mcsp_pkg::PH_SKIP;
				end else begin
					phase_d = mcsp_pkg::PH_DONE;
					emit    = 1'b1;
					res.result_kind = mcsp_pkg::KIND_NOT_SONG;
				end
			end
			mcsp_pkg::PH_SKIP: begin
				skip_d = skip_m;
				if (skip_m == '0) begin
					phase_d = mcsp_pkg::PH_ADDR_LO;
				end
			end
			mcsp_pkg::PH_ADDR_LO: begin
				alow_d  = b;
				phase_d = mcsp_pkg::PH_ADDR_HI;
			end
			mcsp_pkg::PH_ADDR_HI: begin
				emit = 1'b1;
				if (addr == '0) begin
					phase_d = mcsp_pkg::PH_DONE;
					res.result_kind = mcsp_pkg::KIND_END;
				end else begin
					chend_d = addr;
					nest_d  = '0;
					res.result_kind     = mcsp_pkg::KIND_CH_START;
					res.channel_address = addr;
					if (pos_n >= addr) begin
						chidx_d = chidx_inc;
						phase_d = mcsp_pkg::PH_ADDR_LO;
					end else begin
						phase_d = mcsp_pkg::PH_OPCODE;
					end
				end
			end
			mcsp_pkg::PH_OPCODE: begin
				res.command = item.command;
				if (mcsp_pkg::CMD_BARE_MASK[item.command] ||
						mcsp_pkg::CMD_INLINE_MASK[item.command] ||
						item.command == mcsp_pkg::CMD_LOOP_END) begin
					emit = 1'b1;
					if (mcsp_pkg::CMD_INLINE_MASK[item.command]) begin
						res.param = item.param;
					end
					if (item.command == mcsp_pkg::CMD_LOOP_START) begin
						nest_d = nest_up;
					end
					if (item.command == mcsp_pkg::CMD_LOOP_END) begin
						nest_d = nest_dn;
						res.bad_loop_end = nest[7] || (nest == '0);
					end
				end else if (end_hit) begin
					phase_d = mcsp_pkg::PH_DONE;
					emit    = 1'b1;
					res.result_kind = mcsp_pkg::KIND_CORRUPT;
					res.command     = '0;
				end else begin
					pcmd_d  = item.command;
					phase_d = mcsp_pkg::PH_EXT1;
				end
			end
			mcsp_pkg::PH_EXT1: begin
				res.command = pcmd;
				res.param   = b;
				if (pcmd == mcsp_pkg::CMD_FUNCTION) begin
					if (b > mcsp_pkg::FUNC_MAX) begin
						emit = 1'b1;
						res.bad_function = 1'b1;
					end else if (b == mcsp_pkg::FUNC_PAIR_LO || b == mcsp_pkg::FUNC_PAIR_HI) begin
						pbyte_d = b;
						phase_d = mcsp_pkg::PH_EXT2;
					end else begin
						emit = 1'b1;
					end
				end else if (pcmd == mcsp_pkg::CMD_REG_WRITE) begin
					if (end_hit) begin
						phase_d = mcsp_pkg::PH_DONE;
						emit    = 1'b1;
						res.result_kind = mcsp_pkg::KIND_CORRUPT;
						res.command     = '0;
						res.param       = '0;
					end else begin
						pbyte_d = b;
						phase_d = mcsp_pkg::PH_EXT2;
					end
				end else begin
					emit = 1'b1;
					if (pcmd == mcsp_pkg::CMD_LOOP_EXT) begin
						nest_d = nest_up;
					end
				end
			end
			mcsp_pkg::PH_EXT2: begin
				emit = 1'b1;
				res.command      = pcmd;
				res.param        = pbyte;
				res.second_param = b;
				res.has_second   = 1'b1;
			end
			mcsp_pkg::PH_DONE: begin
				pos_d = pos;
			end
			default: begin
				phase_d = ph;
			end
		endcase

		// A completed command moves on to the next channel address at the channel end.
		if (emit && res.result_kind == mcsp_pkg::KIND_COMMAND) begin
			if (end_hit) begin
				chidx_d = chidx_inc;
				phase_d = mcsp_pkg::PH_ADDR_LO;
			end else begin
				phase_d = mcsp_pkg::PH_OPCODE;
			end
		end

		res.channel    = chidx;
		res.chip       = !({4'd0, psg_channel_count} > chidx);
		res.loop_depth = nest_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mcsp_pkg::PH_HEADER;
			pos_q       <= '0;
			chend_q     <= '0;
			chidx_q     <= '0;
			nest_q      <= '0;
			skip_q      <= '0;
			pcmd_q      <= '0;
			pbyte_q     <= '0;
			alow_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				chend_q <= chend_d;
				chidx_q <= chidx_d;
				nest_q  <= nest_d;
				skip_q  <= skip_d;
				pcmd_q  <= pcmd_d;
				pbyte_q <= pbyte_d;
				alow_q  <= alow_d;
			end
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.result_kind     = res_q.result_kind;
	assign result.channel         = res_q.channel;
	assign result.chip            = res_q.chip;
	assign result.channel_address = res_q.channel_address;
	assign result.command         = res_q.command;
	assign result.param           = res_q.param;
	assign result.second_param    = res_q.second_param;
	assign result.has_second      = res_q.has_second;
	assign result.loop_depth      = res_q.loop_depth;
	assign result.bad_loop_end    = res_q.bad_loop_end;
	assign result.bad_function    = res_q.bad_function;

endmodule

/* tb/music_command_stream_parser_top_test.sv */
// Self-checking testbench of music_command_stream_parser_top: song words go in through a gapped
// driver, a software parser predicts each result word and a stalling monitor compares them.
// Depends on mcsp_pkg, the mcsp channel interfaces and the parser RTL.
module music_command_stream_parser_top_test;

	localparam int CLK_PERIOD     = 8;
	localparam int TIMEOUT_CYCLES = 800000;
	localparam int RANDOM_WORDS   = 1850;
	localparam int SETTLE_CYCLES  = 16;

	localparam logic [7:0] OP_SLIDE_FIRST = 8'h93;
	localparam logic [7:0] OP_SLIDE_LAST  = 8'h96;
	localparam logic [7:0] OP_LOOP_START  = 8'h62;
	localparam logic [7:0] OP_LOOP_END    = 8'h72;
	localparam logic [7:0] OP_EXT_FIRST   = 8'hfa;
	localparam logic [7:0] OP_LOOP_EXT    = 8'hfb;
	localparam logic [7:0] OP_REG_WRITE   = 8'hfd;
	localparam logic [7:0] OP_FUNCTION    = 8'hff;

	// Sizes of the opcode ranges, first range in the top byte.
	localparam logic [159:0] RANGE_SIZES = {8'h24, 8'h01, 8'h02, 8'h08, 8'h02, 8'h10, 8'h20,
		8'h10, 8'h01, 8'h10, 8'h10, 8'h04, 8'h5b, 8'h08, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
		8'h01};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
	} song_word_t;

	logic clk;
	logic arst_n;

	mcsp_song_if   song();
	mcsp_cfg_if    cfg();
	mcsp_result_if result();

	music_command_stream_parser_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.song   (song),
		.cfg    (cfg),
		.result (result)
	);

	song_word_t        song_bytes[$];
	mcsp_pkg::result_t expected_results[$];
	logic [7:0]        chan_buf[$];

	int song_pos;
	int stim_count;
	int errors;
	int checked;
	int settings_used;
	int kind_seen[5];
	bit idle_on;
	int send_gap;
	int stall_left;

	mcsp_pkg::phase_t ph;
	logic [15:0]      pos;
	logic [15:0]      chan_end;
	logic [7:0]       chan_idx;
	int               depth;
	logic [2:0]       skip_cnt;
	logic [4:0]       held_cmd;
	logic [7:0]       held_byte;
	logic [7:0]       addr_lo;
	logic [3:0]       psg_count;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("%0t: timeout with %0d words queued and %0d results outstanding", $time,
			song_bytes.size(), expected_results.size());
		$display("Verification failed");
		$finish;
	end

	function automatic void clear_parser();
		ph = mcsp_pkg::PH_HEADER;
		pos = '0;
		chan_end = '0;
		chan_idx = '0;
		depth = 0;
		skip_cnt = '0;
		held_cmd = '0;
		held_byte = '0;
		addr_lo = '0;
	endfunction

	function automatic void report(logic [2:0] kind, logic [15:0] addr, logic [4:0] cmd,
		logic [7:0] par, logic [7:0] sec, logic has2, logic bad_end, logic bad_fn);
		mcsp_pkg::result_t r;
		r.result_kind = kind;
		r.channel = chan_idx;
		r.chip = (chan_idx < {4'd0, psg_count}) ? 1'b0 : 1'b1;
		r.channel_address = addr;
		r.command = cmd;
		r.param = par;
		r.second_param = sec;
		r.has_second = has2;
		r.loop_depth = depth[7:0];
		r.bad_loop_end = bad_end;
		r.bad_function = bad_fn;
		expected_results.push_back(r);
	endfunction

	function automatic void advance_channel();
		if (pos >= chan_end) begin
			if (chan_idx != 8'd255)
				chan_idx++;
			ph = mcsp_pkg::PH_ADDR_LO;
		end else begin
			ph = mcsp_pkg::PH_OPCODE;
		end
	endfunction

	function automatic logic [4:0] range_decode(input logic [7:0] op, output logic [7:0] par);
		int v;
		int i;
		int code;
		par = 8'd0;
		if (op == 8'd0)
			return 5'd0;
		v = op - 1;
		i = 0;
		while (i < 20 && v >= RANGE_SIZES[159 - 8 * i -: 8]) begin
			v -= RANGE_SIZES[159 - 8 * i -: 8];
			i++;
		end
		code = i + 1;
		if (code == 3)
			code = 3 + v;
		else if (code == 5)
			code = 6 + v;
		else if (code == 4)
			code = 5;
		else if (code > 4)
			code += 2;
		par = v[7:0];
		return code[4:0];
	endfunction

	function automatic void parse_song_byte(logic [7:0] b, logic first);
		logic [4:0]  code;
		logic [7:0]  par;
		logic [15:0] addr;
		logic        bad;
		if (first)
			clear_parser();
		case (ph)
			mcsp_pkg::PH_HEADER: begin
				pos = 16'd1;
				if (b == mcsp_pkg::HDR_LONG) begin
					skip_cnt = mcsp_pkg::HDR_LONG_SKIP;
					ph = mcsp_pkg::PH_SKIP;
				end else if (b == mcsp_pkg::HDR_SHORT) begin
					skip_cnt = mcsp_pkg::HDR_SHORT_SKIP;
					ph = mcsp_pkg::PH_SKIP;
				end else begin
					ph = mcsp_pkg::PH_DONE;
					report(mcsp_pkg::KIND_NOT_SONG, 16'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
				end
			end
			mcsp_pkg::PH_SKIP: begin
				pos++;
				if (skip_cnt != 0)
					skip_cnt--;
				if (skip_cnt == 0)
					ph = mcsp_pkg::PH_ADDR_LO;
			end
			mcsp_pkg::PH_ADDR_LO: begin
				pos++;
				addr_lo = b;
				ph = mcsp_pkg::PH_ADDR_HI;
			end
			mcsp_pkg::PH_ADDR_HI: begin
				addr = {b, addr_lo};
				pos++;
				if (addr == 16'd0) begin
					ph = mcsp_pkg::PH_DONE;
					report(mcsp_pkg::KIND_END, 16'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
				end else begin
					chan_end = addr;
					depth = 0;
					report(mcsp_pkg::KIND_CH_START, addr, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
					advance_channel();
				end
			end
			mcsp_pkg::PH_OPCODE: begin
				pos++;
				code = range_decode(b, par);
				if (mcsp_pkg::CMD_BARE_MASK[code]) begin
					report(mcsp_pkg::KIND_COMMAND, 16'd0, code, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
					advance_channel();
				end else if (code == mcsp_pkg::CMD_LOOP_END) begin
					bad = (depth <= 0);
					if (depth > -128)
						depth--;
					report(mcsp_pkg::KIND_COMMAND, 16'd0, code, 8'd0, 8'd0, 1'b0, bad, 1'b0);
					advance_channel();
				end else if (mcsp_pkg::CMD_INLINE_MASK[code]) begin
					if (code == mcsp_pkg::CMD_LOOP_START && depth < 127)
						depth++;
					report(mcsp_pkg::KIND_COMMAND, 16'd0, code, par, 8'd0, 1'b0, 1'b0, 1'b0);
					advance_channel();
				end else if (pos >= chan_end) begin
					ph = mcsp_pkg::PH_DONE;
					report(mcsp_pkg::KIND_CORRUPT, 16'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
				end else begin
					held_cmd = code;
					ph = mcsp_pkg::PH_EXT1;
				end
			end
			mcsp_pkg::PH_EXT1: begin
				pos++;
				if (held_cmd == mcsp_pkg::CMD_FUNCTION) begin
					if (b > mcsp_pkg::FUNC_MAX) begin
						report(mcsp_pkg::KIND_COMMAND, 16'd0, held_cmd, b, 8'd0, 1'b0, 1'b0,
							1'b1);
						advance_channel();
					end else if (b == mcsp_pkg::FUNC_PAIR_LO || b == mcsp_pkg::FUNC_PAIR_HI) begin
						held_byte = b;
						ph = mcsp_pkg::PH_EXT2;
					end else begin
						report(mcsp_pkg::KIND_COMMAND, 16'd0, held_cmd, b, 8'd0, 1'b0, 1'b0,
							1'b0);
						advance_channel();
					end
				end else if (held_cmd == mcsp_pkg::CMD_REG_WRITE) begin
					if (pos >= chan_end) begin
						ph = mcsp_pkg::PH_DONE;
						report(mcsp_pkg::KIND_CORRUPT, 16'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0,
							1'b0);
					end else begin
						held_byte = b;
						ph = mcsp_pkg::PH_EXT2;
					end
				end else begin
					if (held_cmd == mcsp_pkg::CMD_LOOP_EXT && depth < 127)
						depth++;
					report(mcsp_pkg::KIND_COMMAND, 16'd0, held_cmd, b, 8'd0, 1'b0, 1'b0, 1'b0);
					advance_channel();
				end
			end
			mcsp_pkg::PH_EXT2: begin
				pos++;
				report(mcsp_pkg::KIND_COMMAND, 16'd0, held_cmd, held_byte, b, 1'b1, 1'b0, 1'b0);
				advance_channel();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void put_byte(logic [7:0] b, logic first, logic counted);
		song_word_t w;
		w.data_byte = b;
		w.first_of_file = first;
		song_bytes.push_back(w);
		song_pos++;
		if (counted)
			stim_count++;
	endfunction

	function automatic void put_addr(logic [15:0] a);
		put_byte(a[7:0], 1'b0, 1'b1);
		put_byte(a[15:8], 1'b0, 1'b1);
	endfunction

	function automatic void start_song(logic long_hdr, logic first);
		put_byte(long_hdr ? mcsp_pkg::HDR_LONG : mcsp_pkg::HDR_SHORT, first, 1'b1);
		song_pos = 1;
		repeat (long_hdr ? mcsp_pkg::HDR_LONG_SKIP : mcsp_pkg::HDR_SHORT_SKIP)
			put_byte(8'($urandom), 1'b0, 1'b1);
	endfunction

	function automatic void add_command(logic [7:0] op);
		logic [7:0] fn;
		chan_buf.push_back(op);
		if (op == OP_FUNCTION) begin
			fn = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 11));
			chan_buf.push_back(fn);
			if (fn == mcsp_pkg::FUNC_PAIR_LO || fn == mcsp_pkg::FUNC_PAIR_HI)
				chan_buf.push_back(8'($urandom));
		end else if (op == OP_REG_WRITE) begin
			chan_buf.push_back(8'($urandom));
			chan_buf.push_back(8'($urandom));
		end else if (op >= OP_EXT_FIRST || (op >= OP_SLIDE_FIRST && op <= OP_SLIDE_LAST)) begin
			chan_buf.push_back(8'($urandom));
		end
	endfunction

	// A nonzero delta moves the end address off the last command boundary.
	function automatic void close_channel(int delta);
		int          end_at;
		logic [15:0] a;
		end_at = song_pos + 2 + chan_buf.size() + delta;
		a = end_at[15:0];
		if (a == 16'd0)
			a = 16'd1;
		put_addr(a);
		foreach (chan_buf[i])
			put_byte(chan_buf[i], 1'b0, 1'b1);
		chan_buf.delete();
	endfunction

	function automatic void empty_channel();
		put_addr(16'($urandom_range(1, song_pos + 2)));
	endfunction

	function automatic void random_song();
		int         n_ch;
		int         n_cmd;
		int         delta;
		int         fate;
		logic [7:0] op;
		start_song(1'($urandom_range(0, 1)), 1'b1);
		n_ch = $urandom_range(1, 5);
		for (int c = 0; c < n_ch; c++) begin
			if ($urandom_range(0, 11) == 0) begin
				empty_channel();
			end else begin
				n_cmd = $urandom_range(1, 10);
				repeat (n_cmd) begin
					if ($urandom_range(0, 3) == 0)
						op = 8'(OP_EXT_FIRST + $urandom_range(0, 5));
					else
						op = 8'($urandom_range(0, 255));
					add_command(op);
				end
				delta = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
				close_channel(delta);
			end
		end
		fate = $urandom_range(0, 99);
		if (fate < 85) begin
			put_addr(16'd0);
		end else if (fate >= 93) begin
			put_addr(16'd0);
			repeat ($urandom_range(1, 4))
				put_byte(8'($urandom), 1'b0, 1'b0);
		end
	endfunction

	function automatic void random_chunk();
		int         pick;
		int         n;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			random_song();
		end else if (pick < 88) begin
			do
				b = 8'($urandom);
			while (b == mcsp_pkg::HDR_LONG || b == mcsp_pkg::HDR_SHORT);
			put_byte(b, 1'b1, 1'b1);
			n = $urandom_range(0, 3);
			repeat (n)
				put_byte(8'($urandom), 1'b0, 1'b0);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n)
				put_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b1);
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	task automatic wait_idle();
		int spins;
		while (song_bytes.size() != 0 || song.valid)
			@(negedge clk);
		spins = 0;
		while (expected_results.size() != 0 && spins < 4000) begin
			@(posedge clk);
			spins++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_psg(logic [3:0] v);
		@(posedge clk);
		cfg.psg_channel_count <= v;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		psg_count = v;
		settings_used++;
	endtask

	always @(posedge clk) begin : drive_song
		logic       keep_valid;
		song_word_t w;
		if (arst_n) begin
			keep_valid = song.valid;
			if (song.valid && song.ready) begin
				parse_song_byte(song.data_byte, song.first_of_file);
				keep_valid = 1'b0;
			end
			if (!keep_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (song_bytes.size() != 0) begin
					w = song_bytes.pop_front();
					song.data_byte <= w.data_byte;
					song.first_of_file <= w.first_of_file;
					keep_valid = 1'b1;
					send_gap = pick_gap();
				end
			end
			song.valid <= keep_valid;
		end
	end

	always @(posedge clk) begin : watch_results
		mcsp_pkg::result_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (result.result_kind <= mcsp_pkg::KIND_CORRUPT)
					kind_seen[result.result_kind]++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result of kind %0d arrived with nothing expected", $time,
						result.result_kind);
				end else begin
					want = expected_results.pop_front();
					checked++;
					check_field("result_kind", 16'(want.result_kind), 16'(result.result_kind));
					check_field("channel", 16'(want.channel), 16'(result.channel));
					check_field("chip", 16'(want.chip), 16'(result.chip));
					check_field("channel_address", want.channel_address,
						result.channel_address);
					check_field("command", 16'(want.command), 16'(result.command));
					check_field("param", 16'(want.param), 16'(result.param));
					check_field("second_param", 16'(want.second_param),
						16'(result.second_param));
					check_field("has_second", 16'(want.has_second), 16'(result.has_second));
					check_field("loop_depth", 16'({want.loop_depth}),
						16'({result.loop_depth}));
					check_field("bad_loop_end", 16'(want.bad_loop_end),
						16'(result.bad_loop_end));
					check_field("bad_function", 16'(want.bad_function),
						16'(result.bad_function));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin : run_test
		int phase_words;
		int phase_no;
		song.valid = 1'b0;
		song.data_byte = '0;
		song.first_of_file = 1'b0;
		cfg.valid = 1'b0;
		cfg.psg_channel_count = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		psg_count = mcsp_pkg::PSG_RESET;
		clear_parser();
		idle_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// The first header arrives without the first-of-file flag. The first channel ends one
		// word early inside a paired function, then come an empty channel and the song end.
		start_song(1'b0, 1'b0);
		chan_buf = '{8'h00, OP_LOOP_END, OP_REG_WRITE, 8'h5a, 8'ha5, OP_FUNCTION, 8'h0c,
			OP_FUNCTION, mcsp_pkg::FUNC_PAIR_HI, 8'h77};
		close_channel(-1);
		put_addr(16'd1);
		put_addr(16'd0);
		put_byte(8'h55, 1'b0, 1'b0);
		put_byte(8'h00, 1'b1, 1'b1);
		start_song(1'b0, 1'b1);
		chan_buf.push_back(OP_FUNCTION);
		close_channel(0);
		put_byte(8'h00, 1'b0, 1'b0);
		wait_idle();

		stim_count = 0;
		write_psg(4'd0);
		while (stim_count < 320)
			random_chunk();
		wait_idle();

		// Nesting runs into both saturation limits, and the channel count runs past 255.
		write_psg(4'd15);
		start_song(1'b1, 1'b1);
		repeat (135)
			add_command(($urandom_range(0, 7) == 0) ? OP_LOOP_EXT :
				8'(OP_LOOP_START + $urandom_range(0, 15)));
		close_channel(0);
		repeat (135)
			add_command(OP_LOOP_END);
		close_channel(0);
		put_addr(16'd0);
		start_song(1'b0, 1'b1);
		repeat (258)
			empty_channel();
		repeat (3)
			add_command(8'($urandom));
		close_channel(0);
		put_addr(16'd0);
		wait_idle();

		phase_no = 0;
		while (stim_count < RANDOM_WORDS) begin
			write_psg(4'($urandom_range(0, 15)));
			idle_on = (phase_no % 3) != 1;
			phase_words = (stim_count + 320 < RANDOM_WORDS) ? stim_count + 320 : RANDOM_WORDS;
			while (stim_count < phase_words)
				random_chunk();
			wait_idle();
			phase_no++;
		end

		if (expected_results.size() != 0) begin
			errors += expected_results.size();
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
		end
		$display("Covered %0d song words and %0d chip split settings; %0d results checked",
			stim_count, settings_used, checked);
		$display("(%0d channel starts, %0d commands, %0d ends, %0d rejected, %0d corrupt).",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
